// File: design/fsa_pkg.sv
`timescale 1ns / 1ps

package fsa_pkg;

   // fixed field widths
   localparam int IDX_W     = 16;
   localparam int KEY_W     = 32;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int STAT_W    = 2;
   localparam int STORED_W  = 9;
   localparam int ACTIVE_W  = 5;
   localparam int ALLOC_W   = 9;

   // divider retires two quotient bits a cycle
   localparam int DIV_STEPS = IDX_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      KIND_SET    = 2'd0,
      KIND_GET    = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_RANGE     = 2'd1,
      STAT_DEL_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAGMENTS = 1'd0,
      REG_LENGTH    = 1'd1
   } csr_reg_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] quotient;
      logic [CFG_W-1:0] remainder;
   } div_out_type;

endpackage

// File: design/fsa_req_if.sv
`timescale 1ns / 1ps

interface fsa_req_if import fsa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic [IDX_W-1:0]        index;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output kind, output index, output key, input ready);
   modport sink (input valid, input kind, input index, input key, output ready);
endinterface

// File: design/fsa_rsp_if.sv
`timescale 1ns / 1ps

interface fsa_rsp_if import fsa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic signed [KEY_W-1:0] value;
   logic                    value_valid;
   logic                    fragment_spawned;
   logic                    fragment_released;
   logic [STORED_W-1:0]     stored_count;
   logic [ACTIVE_W-1:0]     active_fragments;
   logic [ALLOC_W-1:0]      allocated_cells;

   modport source (output valid, output status, output value, output value_valid,
                   output fragment_spawned, output fragment_released,
                   output stored_count, output active_fragments,
                   output allocated_cells, input ready);
   modport sink (input valid, input status, input value, input value_valid,
                 input fragment_spawned, input fragment_released,
                 input stored_count, input active_fragments,
                 input allocated_cells, output ready);
endinterface

// File: design/fragmented_sparse_array.sv
`timescale 1ns / 1ps
// set, get, delete: the request passes through 8 radix-4 divider steps, memory read, read
// state, read-modify-write and response load before the next request is taken; out of range
// index: straight to the response load; clear all: the clearing pass over all
// MAX_FRAGMENTS*MAX_FRAGMENT_LENGTH entries, one entry a cycle, then the response load
// reset and every register write start that same clearing pass; no request is taken until it ends
module fragmented_sparse_array import fsa_pkg::*; #(
   parameter int MAX_FRAGMENTS       = 16,
   parameter int MAX_FRAGMENT_LENGTH = 16,
   parameter int KEY_WIDTH           = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   fsa_req_if.sink              req_bus,
   fsa_rsp_if.source            rsp_bus
);

   localparam int SLOTS  = MAX_FRAGMENTS * MAX_FRAGMENT_LENGTH;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FRAG_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAGMENT_LENGTH + 1);
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam int ACT_W  = $clog2(MAX_FRAGMENTS + 1);
   localparam int CELL_W = KEY_WIDTH + 1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DIV   = 6'b000100,
      S_READ  = 6'b001000,
      S_RMW   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v, input int hi);
      begin
         if (v == '0) begin
            clamp_reg = CFG_W'(1);
         end else if (32'(v) > hi) begin
            clamp_reg = CFG_W'(hi);
         end else begin
            clamp_reg = v;
         end
      end
   endfunction

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        fin_ff, flen_ff;
   logic [SLOT_W-1:0]       clr_ff;
   logic                    clr_rsp_ff;
   logic [TOT_W-1:0]        total_ff;
   logic [ACT_W-1:0]        active_ff;
   kind_type                kind_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [SLOT_W-1:0]       slot_ff;

   status_type              res_status_ff;
   logic signed [KEY_W-1:0] res_value_ff;
   logic                    res_vvalid_ff, res_spawn_ff, res_rel_ff;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic signed [KEY_W-1:0] rsp_value_ff;
   logic                    rsp_vvalid_ff, rsp_spawn_ff, rsp_rel_ff;
   logic [STORED_W-1:0]     rsp_stored_ff;
   logic [ACTIVE_W-1:0]     rsp_active_ff;
   logic [ALLOC_W-1:0]      rsp_alloc_ff;

   // cell memory holds {valid, value}; fragment memory holds the cell count
   logic [CELL_W-1:0]       cell_mem [SLOTS];
   logic [CNT_W-1:0]        frag_mem [MAX_FRAGMENTS];
   logic [CELL_W-1:0]       cell_rd_ff;
   logic [CNT_W-1:0]        frag_rd_ff;

   logic                    req_fire, rsp_free, clear_last;
   logic [2*CFG_W-1:0]      limit;
   logic                    in_range;
   kind_type                req_kind;
   div_out_type             div_out;
   logic                    div_start;
   logic [SLOT_W-1:0]       slot_rd;
   logic [FRAG_W-1:0]       frag_idx;

   logic                    cell_we, frag_we;
   logic [SLOT_W-1:0]       cell_wa;
   logic [FRAG_W-1:0]       frag_wa;
   logic [CELL_W-1:0]       cell_wd;
   logic [CNT_W-1:0]        frag_wd;

   logic                          cur_valid;
   logic signed [KEY_WIDTH-1:0]   cur_val;
   logic [CNT_W-1:0]              cur_cnt;
   status_type                    rmw_status;
   logic signed [KEY_W-1:0]       rmw_value;
   logic                          rmw_vvalid, rmw_spawn, rmw_rel;
   logic [TOT_W-1:0]              rmw_total;
   logic [ACT_W-1:0]              rmw_active;
   logic                          rmw_cell_we, rmw_frag_we;
   logic [CELL_W-1:0]             rmw_cell_wd;
   logic [CNT_W-1:0]              rmw_frag_wd;

   assign req_kind   = kind_type'(req_bus.kind);
   assign limit      = fin_ff * flen_ff;
   assign in_range   = req_bus.index < IDX_W'(limit);
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   assign clear_last = (clr_ff == SLOT_W'(SLOTS - 1));
   assign div_start  = req_fire && (req_kind != KIND_CLEAR) && in_range;

   fsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_bus.index),
      .divisor  (flen_ff),
      .result   (div_out)
   );

   // quotient stays below the clamped fragment count, remainder below the length
   assign frag_idx = FRAG_W'(div_out.quotient);
   assign slot_rd  = SLOT_W'(32'(div_out.quotient) * MAX_FRAGMENT_LENGTH
                             + 32'(div_out.remainder));

   // read-modify-write of one cell and its fragment count
   assign cur_valid = cell_rd_ff[KEY_WIDTH];
   assign cur_val   = cell_rd_ff[KEY_WIDTH-1:0];
   assign cur_cnt   = frag_rd_ff;

   always_comb begin
      rmw_status  = STAT_OK;
      rmw_value   = '0;
      rmw_vvalid  = 1'b0;
      rmw_spawn   = 1'b0;
      rmw_rel     = 1'b0;
      rmw_total   = total_ff;
      rmw_active  = active_ff;
      rmw_cell_we = 1'b0;
      rmw_frag_we = 1'b0;
      rmw_cell_wd = '0;
      rmw_frag_wd = cur_cnt;
      case (kind_ff)
         KIND_SET: begin
            rmw_cell_we = 1'b1;
            rmw_cell_wd = {1'b1, KEY_WIDTH'(key_ff)};
            if (!cur_valid) begin
               rmw_frag_we = 1'b1;
               rmw_frag_wd = cur_cnt + CNT_W'(1);
               rmw_total   = total_ff + TOT_W'(1);
               if (cur_cnt == '0) begin
                  rmw_spawn  = 1'b1;
                  rmw_active = active_ff + ACT_W'(1);
               end
            end
         end
         KIND_GET: begin
            if (cur_valid) begin
               rmw_value  = KEY_W'(cur_val);
               rmw_vvalid = 1'b1;
            end
         end
         KIND_DELETE: begin
            if (!cur_valid) begin
               rmw_status = STAT_DEL_EMPTY;
            end else begin
               rmw_cell_we = 1'b1;
               rmw_frag_we = 1'b1;
               rmw_frag_wd = cur_cnt - CNT_W'(1);
               rmw_total   = total_ff - TOT_W'(1);
               if (cur_cnt == CNT_W'(1)) begin
                  rmw_rel    = 1'b1;
                  rmw_active = active_ff - ACT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // write port shared by the clearing pass and the modify step
   always_comb begin
      cell_we = 1'b0;
      frag_we = 1'b0;
      cell_wa = slot_ff;
      frag_wa = frag_idx;
      cell_wd = rmw_cell_wd;
      frag_wd = rmw_frag_wd;
      if (state_ff == S_CLEAR) begin
         cell_we = 1'b1;
         cell_wa = clr_ff;
         cell_wd = '0;
         frag_we = (32'(clr_ff) < MAX_FRAGMENTS);
         frag_wa = FRAG_W'(clr_ff);
         frag_wd = '0;
      end else if (state_ff == S_RMW) begin
         cell_we = rmw_cell_we;
         frag_we = rmw_frag_we;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_rd_ff <= cell_mem[slot_rd];
   end

   always_ff @(posedge clock) begin
      if (frag_we) begin
         frag_mem[frag_wa] <= frag_wd;
      end
      frag_rd_ff <= frag_mem[frag_idx];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_last) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (in_range) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DIV: begin
            if (div_out.done) begin
               state_in = S_READ;
            end
         end
         S_READ:  state_in = S_RMW;
         S_RMW:   state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
      if (csr_we) begin
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         total_ff     <= '0;
         active_ff    <= '0;
         fin_ff       <= clamp_reg(CFG_W'(16), MAX_FRAGMENTS);
         flen_ff      <= clamp_reg(CFG_W'(16), MAX_FRAGMENT_LENGTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + SLOT_W'(1);
         end
         if (state_ff == S_RMW) begin
            total_ff  <= rmw_total;
            active_ff <= rmw_active;
         end
         if (req_fire && req_kind == KIND_CLEAR) begin
            clr_ff     <= '0;
            clr_rsp_ff <= 1'b1;
            total_ff   <= '0;
            active_ff  <= '0;
         end
         if (state_ff == S_DONE && rsp_free) begin
            clr_rsp_ff <= 1'b0;
         end
         if (csr_we) begin
            clr_ff    <= '0;
            total_ff  <= '0;
            active_ff <= '0;
            case (csr_reg_type'(csr_index))
               REG_FRAGMENTS: fin_ff  <= clamp_reg(csr_data, MAX_FRAGMENTS);
               REG_LENGTH:    flen_ff <= clamp_reg(csr_data, MAX_FRAGMENT_LENGTH);
               default: begin
               end
            endcase
         end
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff       <= req_kind;
         key_ff        <= req_bus.key;
         res_status_ff <= (req_kind == KIND_CLEAR || in_range) ? STAT_OK : STAT_RANGE;
         res_value_ff  <= '0;
         res_vvalid_ff <= 1'b0;
         res_spawn_ff  <= 1'b0;
         res_rel_ff    <= 1'b0;
      end
      if (state_ff == S_READ) begin
         slot_ff <= slot_rd;
      end
      if (state_ff == S_RMW) begin
         res_status_ff <= rmw_status;
         res_value_ff  <= rmw_value;
         res_vvalid_ff <= rmw_vvalid;
         res_spawn_ff  <= rmw_spawn;
         res_rel_ff    <= rmw_rel;
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_vvalid_ff <= res_vvalid_ff;
         rsp_spawn_ff  <= res_spawn_ff;
         rsp_rel_ff    <= res_rel_ff;
         rsp_stored_ff <= STORED_W'(32'(total_ff));
         rsp_active_ff <= ACTIVE_W'(32'(active_ff));
         rsp_alloc_ff  <= ALLOC_W'(32'(active_ff) * 32'(flen_ff));
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_status_ff;
   assign rsp_bus.value             = rsp_value_ff;
   assign rsp_bus.value_valid       = rsp_vvalid_ff;
   assign rsp_bus.fragment_spawned  = rsp_spawn_ff;
   assign rsp_bus.fragment_released = rsp_rel_ff;
   assign rsp_bus.stored_count      = rsp_stored_ff;
   assign rsp_bus.active_fragments  = rsp_active_ff;
   assign rsp_bus.allocated_cells   = rsp_alloc_ff;

   // a held cell always lies in a fragment with a nonzero count
   a_del_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW && kind_ff == KIND_DELETE && cur_valid) |-> (cur_cnt != '0))
      else $error("delete of a held cell found an empty fragment");

   a_tot_act: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) == (active_ff != '0))
      else $error("stored count and active fragments disagree");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_out.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   a_act_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (32'(active_ff) <= 32'(fin_ff)))
      else $error("more active fragments than configured");

endmodule

// File: design/fsa_div.sv
`timescale 1ns / 1ps

module fsa_div import fsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IDX_W-1:0] dividend,
   input  logic [CFG_W-1:0] divisor,
   output div_out_type      result
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0]     dvd_ff;
   logic [IDX_W-1:0]     quo_ff;
   logic [CFG_W-1:0]     rem_ff;
   logic [CFG_W-1:0]     dsr_ff;
   logic [CFG_W:0]       step1;
   logic [CFG_W:0]       step2;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [CFG_W-1:0] dsr);
      logic [CFG_W:0] t;
      logic [CFG_W:0] d;
      begin
         t = {rem, bit_in};
         d = {1'b0, dsr};
         if (t >= d) begin
            div_step = {1'b1, CFG_W'(t - d)};
         end else begin
            div_step = {1'b0, t[CFG_W-1:0]};
         end
      end
   endfunction

   assign step1 = div_step(rem_ff, dvd_ff[IDX_W-1], dsr_ff);
   assign step2 = div_step(step1[CFG_W-1:0], dvd_ff[IDX_W-2], dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[IDX_W-3:0], 2'b00};
         quo_ff <= {quo_ff[IDX_W-3:0], step1[CFG_W], step2[CFG_W]};
         rem_ff <= step2[CFG_W-1:0];
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fsa_pkg::*;

   localparam int CELLS         = 256;
   localparam int FRAG_SLOTS    = 16;
   localparam int FRAG_MAX_LEN  = 16;
   // covers the clearing pass that follows a register write or a clear all
   localparam int SETTLE_CYCLES = CELLS + 8;

   typedef struct {
      logic [STAT_W-1:0]       status;
      logic signed [KEY_W-1:0] value;
      logic                    value_valid;
      logic                    spawned;
      logic                    released;
      logic [STORED_W-1:0]     stored;
      logic [ACTIVE_W-1:0]     active;
      logic [ALLOC_W-1:0]      allocated;
   } array_result_type;

   class sparse_array_shadow_type;
      int unsigned             frag_count;
      int unsigned             frag_len;
      bit                      held [CELLS];
      logic signed [KEY_W-1:0] contents [CELLS];
      int unsigned             fill [FRAG_SLOTS];
      int unsigned             stored;
      int unsigned             active;
      array_result_type        pending_results [$];
      int unsigned             checked;
      int unsigned             errors;

      function new();
         frag_count = FRAG_SLOTS;
         frag_len   = FRAG_MAX_LEN;
         checked    = 0;
         errors     = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (held[i]) begin
            held[i]     = 1'b0;
            contents[i] = '0;
         end
         foreach (fill[i])
            fill[i] = 0;
         stored = 0;
         active = 0;
      endfunction

      function int unsigned capacity();
         return frag_count * frag_len;
      endfunction

      function bit holds(int unsigned idx);
         return idx < capacity() && held[idx];
      endfunction

      // zero reads as one, anything above the maximum reads as the maximum
      function void apply_register(csr_reg_type which, logic [CFG_W-1:0] data);
         int unsigned v;
         v = (data == 0) ? 1 : data;
         if (which == REG_FRAGMENTS)
            frag_count = (v > FRAG_SLOTS) ? FRAG_SLOTS : v;
         else
            frag_len = (v > FRAG_MAX_LEN) ? FRAG_MAX_LEN : v;
         wipe();
      endfunction

      function void predict_request(kind_type kind, logic [IDX_W-1:0] idx,
                                    logic signed [KEY_W-1:0] key);
         array_result_type r;
         int unsigned      frag;
         r.status      = STAT_OK;
         r.value       = '0;
         r.value_valid = 1'b0;
         r.spawned     = 1'b0;
         r.released    = 1'b0;
         if (kind == KIND_CLEAR) begin
            wipe();
         end else if (idx >= capacity()) begin
            r.status = STAT_RANGE;
         end else begin
            frag = idx / frag_len;
            case (kind)
               KIND_SET: begin
                  if (!held[idx]) begin
                     if (fill[frag] == 0) begin
                        r.spawned = 1'b1;
                        active++;
                     end
                     held[idx] = 1'b1;
                     fill[frag]++;
                     stored++;
                  end
                  contents[idx] = key;
               end
               KIND_GET: begin
                  if (held[idx]) begin
                     r.value       = contents[idx];
                     r.value_valid = 1'b1;
                  end
               end
               KIND_DELETE: begin
                  if (!held[idx]) begin
                     r.status = STAT_DEL_EMPTY;
                  end else begin
                     held[idx]     = 1'b0;
                     contents[idx] = '0;
                     stored--;
                     fill[frag]--;
                     if (fill[frag] == 0) begin
                        r.released = 1'b1;
                        active--;
                     end
                  end
               end
               default: ;
            endcase
         end
         r.stored    = STORED_W'(stored);
         r.active    = ACTIVE_W'(active);
         r.allocated = ALLOC_W'(active * frag_len);
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] ERROR %s", $time, msg);
         errors++;
      endtask

      task match_response(array_result_type got);
         array_result_type want;
         if (pending_results.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.status !== want.status)
            report($sformatf("response %0d status %0d, expected %0d",
                             checked, got.status, want.status));
         if (got.value !== want.value)
            report($sformatf("response %0d value %0h, expected %0h",
                             checked, got.value, want.value));
         if (got.value_valid !== want.value_valid)
            report($sformatf("response %0d value_valid %0b, expected %0b",
                             checked, got.value_valid, want.value_valid));
         if (got.spawned !== want.spawned)
            report($sformatf("response %0d fragment_spawned %0b, expected %0b",
                             checked, got.spawned, want.spawned));
         if (got.released !== want.released)
            report($sformatf("response %0d fragment_released %0b, expected %0b",
                             checked, got.released, want.released));
         if (got.stored !== want.stored)
            report($sformatf("response %0d stored_count %0d, expected %0d",
                             checked, got.stored, want.stored));
         if (got.active !== want.active)
            report($sformatf("response %0d active_fragments %0d, expected %0d",
                             checked, got.active, want.active));
         if (got.allocated !== want.allocated)
            report($sformatf("response %0d allocated_cells %0d, expected %0d",
                             checked, got.allocated, want.allocated));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   bit                   calm;

   fsa_req_if req_bus ();
   fsa_rsp_if rsp_bus ();

   sparse_array_shadow_type shadow;

   fragmented_sparse_array dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // response side stalls in short bursts unless the run has gone calm
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      array_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status      = rsp_bus.status;
         got.value       = rsp_bus.value;
         got.value_valid = rsp_bus.value_valid;
         got.spawned     = rsp_bus.fragment_spawned;
         got.released    = rsp_bus.fragment_released;
         got.stored      = rsp_bus.stored_count;
         got.active      = rsp_bus.active_fragments;
         got.allocated   = rsp_bus.allocated_cells;
         shadow.match_response(got);
      end
   end

   task automatic send_request(kind_type kind, logic [IDX_W-1:0] idx,
                               logic signed [KEY_W-1:0] key);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.index <= idx;
      req_bus.key   <= key;
      do @(posedge clock); while (!req_bus.ready);
      shadow.predict_request(kind, idx, key);
   endtask

   task automatic hold_sender(int unsigned cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      hold_sender(1);
      while (shadow.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_reg_type which, logic [CFG_W-1:0] data);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_data  <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      shadow.apply_register(which, data);
   endtask

   task automatic random_request();
      kind_type                kind;
      logic [IDX_W-1:0]        idx;
      logic signed [KEY_W-1:0] key;
      int unsigned             cap;
      int unsigned             roll;
      int unsigned             tries;
      cap  = shadow.capacity();
      roll = $urandom_range(0, 99);
      if (roll < 38)
         kind = KIND_SET;
      else if (roll < 63)
         kind = KIND_GET;
      else if (roll < 96)
         kind = KIND_DELETE;
      else
         kind = KIND_CLEAR;

      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         idx = IDX_W'($urandom);
      end else if (roll < 12) begin
         idx = IDX_W'(cap + $urandom_range(0, 3));
      end else begin
         idx = IDX_W'($urandom_range(0, cap - 1));
         // lean gets and deletes toward cells that hold a value
         if (kind != KIND_SET && $urandom_range(0, 1) == 1)
            for (tries = 0; tries < 8 && !shadow.holds(idx); tries++)
               idx = IDX_W'($urandom_range(0, cap - 1));
      end

      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: key = 32'sh8000_0000;
            1: key = 32'sh7fff_ffff;
            2: key = -32'sd1;
            default: key = '0;
         endcase
      end else begin
         key = $urandom;
      end

      if (!calm && $urandom_range(0, 4) == 0)
         hold_sender($urandom_range(1, 3));
      send_request(kind, idx, key);
   endtask

   task automatic run_phase(logic [CFG_W-1:0] frags, logic [CFG_W-1:0] len,
                            int unsigned count, int unsigned calm_tail);
      write_register(REG_FRAGMENTS, frags);
      write_register(REG_LENGTH, len);
      for (int unsigned n = 0; n < count; n++) begin
         if (n == count / 2)
            drain();
         if (n + calm_tail >= count)
            calm = 1'b1;
         random_request();
      end
   endtask

   initial begin
      shadow        = new();
      calm          = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = REG_FRAGMENTS;
      csr_data      = '0;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_SET;
      req_bus.index = '0;
      req_bus.key   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at the reset configuration
      send_request(KIND_GET, 16'd0, '0);
      send_request(KIND_SET, 16'd0, 32'sh7fff_ffff);
      send_request(KIND_SET, 16'd255, 32'sh8000_0000);
      send_request(KIND_GET, 16'd0, '0);
      send_request(KIND_GET, 16'd255, '0);
      send_request(KIND_SET, 16'd0, -32'sd1);
      send_request(KIND_GET, 16'd0, '0);
      send_request(KIND_SET, 16'd1, 32'sh5a5a_a5a5);
      send_request(KIND_DELETE, 16'd0, '0);
      send_request(KIND_DELETE, 16'd0, '0);
      send_request(KIND_DELETE, 16'd1, '0);
      send_request(KIND_DELETE, 16'd255, '0);
      send_request(KIND_SET, 16'd256, 32'sd12345);
      send_request(KIND_GET, 16'hffff, '0);
      send_request(KIND_DELETE, 16'h8000, '0);
      send_request(KIND_SET, 16'd17, 32'sd1);
      send_request(KIND_SET, 16'd200, -32'sd7);
      send_request(KIND_CLEAR, 16'haaaa, 32'sh5555_5555);
      send_request(KIND_GET, 16'd17, '0);
      send_request(KIND_GET, 16'd200, '0);
      send_request(KIND_DELETE, 16'd200, '0);
      send_request(KIND_SET, 16'd34, '0);
      send_request(KIND_CLEAR, 16'h5555, 32'shaaaa_aaaa);

      run_phase(5'd16, 5'd16, 380, 0);
      run_phase(5'd1, 5'd1, 100, 0);
      run_phase(5'd0, 5'd31, 150, 0);
      run_phase(5'd31, 5'd0, 200, 0);
      run_phase(5'd17, 5'd17, 300, 0);
      run_phase(5'd5, 5'd3, 200, 0);
      run_phase(5'd10, 5'd21, 180, 0);
      run_phase(5'd16, 5'd16, 320, 200);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", shadow.pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
